// File: design/sm83_cpu_step_partial_assert.svh
// Assertion macros used by the controller.
`ifndef SM83_CPU_STEP_PARTIAL_ASSERT_SVH
`define SM83_CPU_STEP_PARTIAL_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SM83_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SM83_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/sm83_pkg.sv
package sm83_pkg;

   // Default memory depth in bytes.
   localparam int MEM_DEPTH_DEF = 65536;

   // Command codes on the request word.
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_EXEC  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   // Opcode that stores SP at an absolute address with two writes.
   localparam logic [7:0] OP_LD_A16_SP = 8'h08;

   // Register values after reset.
   localparam logic [7:0]  RST_A  = 8'h01;
   localparam logic [3:0]  RST_F  = 4'hB;
   localparam logic [7:0]  RST_B  = 8'h00;
   localparam logic [7:0]  RST_C  = 8'h13;
   localparam logic [7:0]  RST_D  = 8'h00;
   localparam logic [7:0]  RST_E  = 8'hD8;
   localparam logic [7:0]  RST_H  = 8'h01;
   localparam logic [7:0]  RST_L  = 8'h4D;
   localparam logic [15:0] RST_SP = 16'h014D;
   localparam logic [15:0] RST_PC = 16'h0100;

   // Datapath phase commanded by the controller.
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_CMD_WR,
      PH_CMD_RD,
      PH_RD_DONE,
      PH_FETCH_OP,
      PH_FETCH_LO,
      PH_FETCH_HI,
      PH_OPND,
      PH_EXEC,
      PH_WR2
   } phase_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic      take_req;
      phase_type phase;
   } dp_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic two_writes;
   } dp_stat_type;

endpackage

// File: design/sm83_ctrl.sv
`include "sm83_cpu_step_partial_assert.svh"

module sm83_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_opcode,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sm83_pkg::dp_cmd_type cmd,
   input  sm83_pkg::dp_stat_type stat
);
   import sm83_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CMD_WR,
      S_CMD_RD,
      S_RD_DONE,
      S_FETCH_OP,
      S_FETCH_LO,
      S_FETCH_HI,
      S_OPND,
      S_EXEC,
      S_WR2,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take;

   // A new word is taken only while nothing is in flight.
   assign take      = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and response valid.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_opcode)
                  CMD_WRITE: state_in = S_CMD_WR;
                  CMD_EXEC:  state_in = S_FETCH_OP;
                  CMD_READ:  state_in = S_CMD_RD;
                  default: begin
                     state_in     = S_RESP;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_CMD_RD:   state_in = S_RD_DONE;
         S_FETCH_OP: state_in = S_FETCH_LO;
         S_FETCH_LO: state_in = S_FETCH_HI;
         S_FETCH_HI: state_in = S_OPND;
         S_OPND:     state_in = S_EXEC;
         S_EXEC: begin
            if (stat.two_writes) begin
               state_in = S_WR2;
            end else begin
               state_in     = S_RESP;
               rsp_valid_in = 1'b1;
            end
         end
         S_CMD_WR, S_RD_DONE, S_WR2: begin
            state_in     = S_RESP;
            rsp_valid_in = 1'b1;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b0;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register and registered response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Phase command to the datapath.
   always_comb begin
      cmd.take_req = take;
      unique case (state_ff)
         S_CMD_WR:   cmd.phase = PH_CMD_WR;
         S_CMD_RD:   cmd.phase = PH_CMD_RD;
         S_RD_DONE:  cmd.phase = PH_RD_DONE;
         S_FETCH_OP: cmd.phase = PH_FETCH_OP;
         S_FETCH_LO: cmd.phase = PH_FETCH_LO;
         S_FETCH_HI: cmd.phase = PH_FETCH_HI;
         S_OPND:     cmd.phase = PH_OPND;
         S_EXEC:     cmd.phase = PH_EXEC;
         S_WR2:      cmd.phase = PH_WR2;
         default:    cmd.phase = PH_IDLE;
      endcase
   end

   `SM83_ASSERT_IMPL(a_rsp_only_in_resp, rsp_valid_ff, state_ff == S_RESP, "response outside RESP")
   `SM83_ASSERT_NEXT(a_wr2_after_exec, state_ff == S_EXEC && stat.two_writes, state_ff == S_WR2, "second store skipped")
   `SM83_ASSERT_NEXT(a_no_same_cycle_rsp, take && req_opcode != CMD_NOP, !rsp_valid_ff, "response too early")
   `SM83_ASSERT_NEXT(a_rsp_done_idle, rsp_valid_ff && !rsp_stall, state_ff == S_IDLE, "no return to idle")

endmodule

// File: design/sm83_dp.sv
module sm83_dp #(
   parameter int MEM_DEPTH = sm83_pkg::MEM_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sm83_pkg::dp_cmd_type cmd,
   output sm83_pkg::dp_stat_type stat,
   input  logic [1:0]           req_opcode,
   input  logic [15:0]          req_address,
   input  logic [7:0]           req_data,
   output logic [7:0]           rsp_read_data,
   output logic [15:0]          rsp_program_counter,
   output logic [7:0]           rsp_accumulator,
   output logic [3:0]           rsp_flag_bits,
   output logic [15:0]          rsp_pair_bc,
   output logic [15:0]          rsp_pair_de,
   output logic [15:0]          rsp_pair_hl,
   output logic [15:0]          rsp_stack_pointer,
   output logic                 rsp_unknown_instruction
);
   import sm83_pkg::*;

   localparam int AW = $clog2(MEM_DEPTH);

   // Architectural registers.
   logic [7:0]  a_ff, b_ff, c_ff, d_ff, e_ff, h_ff, l_ff;
   logic [3:0]  f_ff;
   logic [15:0] sp_ff, pc_ff;
   // Request and instruction bytes.
   logic [1:0]  rq_op_ff;
   logic [15:0] rq_addr_ff;
   logic [7:0]  rq_data_ff;
   logic [7:0]  op_ff, lo_ff, hi_ff;
   logic [7:0]  rd_ff;
   logic        unk_ff;
   // Byte memory and its registered read data.
   logic [7:0]  mem_ff [MEM_DEPTH];
   logic [7:0]  mem_q_ff;

   logic [15:0] mem_addr;
   logic        mem_we;
   logic [7:0]  mem_wdata;
   logic [15:0] hl, imm16, opnd_addr;
   logic [7:0]  cur8 [8];
   logic [7:0]  nxt8 [8];
   logic [3:0]  nf;
   logic [15:0] nsp, npc;
   logic        ex_we, ex_unk;
   logic [15:0] ex_waddr;
   logic [7:0]  ex_wdata;

   assign hl    = {h_ff, l_ff};
   assign imm16 = {hi_ff, lo_ff};
   assign stat.two_writes = (op_ff == OP_LD_A16_SP);

   // Operand address: LD A,(BC)/(DE) and their stores use the pair, all else HL.
   always_comb begin
      if (op_ff[7:6] == 2'b00 && op_ff[2:0] == 3'd2 && op_ff[5:4] == 2'd0)
         opnd_addr = {b_ff, c_ff};
      else if (op_ff[7:6] == 2'b00 && op_ff[2:0] == 3'd2 && op_ff[5:4] == 2'd1)
         opnd_addr = {d_ff, e_ff};
      else
         opnd_addr = hl;
   end

   // Register file view; index six is the byte read at the operand address.
   always_comb begin
      cur8[0] = b_ff;
      cur8[1] = c_ff;
      cur8[2] = d_ff;
      cur8[3] = e_ff;
      cur8[4] = h_ff;
      cur8[5] = l_ff;
      cur8[6] = mem_q_ff;
      cur8[7] = a_ff;
   end

   // Instruction execution.
   always_comb begin
      logic [2:0]  row;
      logic [1:0]  pair;
      logic        set8_en, set16_en;
      logic [2:0]  set8_idx;
      logic [7:0]  val8, v8, da;
      logic [1:0]  set16_idx;
      logic [15:0] val16, p16;
      logic [16:0] sum17;
      logic [12:0] sumh;
      logic        dc, take_jr;
      row       = op_ff[5:3];
      pair      = op_ff[5:4];
      set8_en   = 1'b0;
      set8_idx  = row;
      val8      = 8'h00;
      set16_en  = 1'b0;
      set16_idx = pair;
      val16     = 16'h0000;
      v8        = cur8[row];
      p16       = (pair == 2'd3) ? sp_ff : {cur8[{pair, 1'b0}], cur8[{pair, 1'b1}]};
      sum17     = {1'b0, hl} + {1'b0, p16};
      sumh      = {1'b0, hl[11:0]} + {1'b0, p16[11:0]};
      da        = a_ff;
      dc        = f_ff[0];
      take_jr   = 1'b0;
      nxt8      = cur8;
      nf        = f_ff;
      nsp       = sp_ff;
      npc       = pc_ff + 16'd1;
      ex_we     = 1'b0;
      ex_waddr  = hl;
      ex_wdata  = 8'h00;
      ex_unk    = 1'b0;
      if (op_ff[7]) begin
         ex_unk = 1'b1;
      end else if (op_ff[6]) begin
         // Register to register move; HALT does nothing.
         if (op_ff != 8'h76) begin
            set8_en = 1'b1;
            val8    = cur8[op_ff[2:0]];
         end
      end else if (op_ff[2:0] == 3'd4) begin
         set8_en = 1'b1;
         val8    = v8 + 8'd1;
         nf[3]   = (val8 == 8'h00);
         nf[2]   = 1'b0;
         nf[1]   = (v8[3:0] == 4'hF);
      end else if (op_ff[2:0] == 3'd5) begin
         set8_en = 1'b1;
         val8    = v8 - 8'd1;
         nf[3]   = (val8 == 8'h00);
         nf[2]   = 1'b1;
         nf[1]   = (v8[3:0] == 4'h0);
      end else if (op_ff[2:0] == 3'd6) begin
         set8_en = 1'b1;
         val8    = lo_ff;
         npc     = pc_ff + 16'd2;
      end else if (op_ff[3:0] == 4'h1) begin
         set16_en = 1'b1;
         val16    = imm16;
         npc      = pc_ff + 16'd3;
      end else if (op_ff[3:0] == 4'h3) begin
         set16_en = 1'b1;
         val16    = p16 + 16'd1;
      end else if (op_ff[3:0] == 4'hB) begin
         set16_en = 1'b1;
         val16    = p16 - 16'd1;
      end else if (op_ff[3:0] == 4'h9) begin
         set16_en  = 1'b1;
         set16_idx = 2'd2;
         val16     = sum17[15:0];
         nf[2]     = 1'b0;
         nf[1]     = sumh[12];
         nf[0]     = sum17[16];
      end else if (op_ff[2:0] == 3'd2) begin
         // Accumulator load or store through a pair, HL with post step.
         if (op_ff[3]) begin
            nxt8[7] = mem_q_ff;
         end else begin
            ex_we    = 1'b1;
            ex_waddr = opnd_addr;
            ex_wdata = a_ff;
         end
         if (pair == 2'd2) begin
            set16_en = 1'b1;
            val16    = hl + 16'd1;
         end else if (pair == 2'd3) begin
            set16_en  = 1'b1;
            set16_idx = 2'd2;
            val16     = hl - 16'd1;
         end
      end else begin
         case (op_ff)
            OP_LD_A16_SP: begin
               ex_we    = 1'b1;
               ex_waddr = imm16;
               ex_wdata = sp_ff[7:0];
               npc      = pc_ff + 16'd3;
            end
            8'h07, 8'h0F, 8'h17, 8'h1F: begin
               case (op_ff[4:3])
                  2'd0: begin nxt8[7] = {a_ff[6:0], a_ff[7]}; nf = {3'b000, a_ff[7]}; end
                  2'd1: begin nxt8[7] = {a_ff[0], a_ff[7:1]}; nf = {3'b000, a_ff[0]}; end
                  2'd2: begin nxt8[7] = {a_ff[6:0], f_ff[0]}; nf = {3'b000, a_ff[7]}; end
                  default: begin nxt8[7] = {f_ff[0], a_ff[7:1]}; nf = {3'b000, a_ff[0]}; end
               endcase
            end
            8'h18, 8'h20, 8'h28, 8'h30, 8'h38: begin
               case (op_ff[5:3])
                  3'd3:    take_jr = 1'b1;
                  3'd4:    take_jr = !f_ff[3];
                  3'd5:    take_jr = f_ff[3];
                  3'd6:    take_jr = !f_ff[0];
                  default: take_jr = f_ff[0];
               endcase
               npc = pc_ff + 16'd2;
               if (take_jr)
                  npc = npc + {{8{lo_ff[7]}}, lo_ff};
            end
            8'h27: begin
               if (!f_ff[2]) begin
                  if (dc || a_ff > 8'h99) begin
                     da = da + 8'h60;
                     dc = 1'b1;
                  end
                  if (f_ff[1] || da[3:0] > 4'h9)
                     da = da + 8'h06;
               end else begin
                  if (dc)
                     da = da - 8'h60;
                  if (f_ff[1])
                     da = da - 8'h06;
               end
               nxt8[7] = da;
               nf[3]   = (da == 8'h00);
               nf[1]   = 1'b0;
               nf[0]   = dc;
            end
            8'h2F: begin
               nxt8[7] = ~a_ff;
               nf[2]   = 1'b1;
               nf[1]   = 1'b1;
            end
            8'h37: begin
               nf[2] = 1'b0;
               nf[1] = 1'b0;
               nf[0] = 1'b1;
            end
            8'h3F: begin
               nf[2] = 1'b0;
               nf[1] = 1'b0;
               nf[0] = !f_ff[0];
            end
            default: ;
         endcase
      end
      // Write back an 8-bit target; index six goes to memory at HL.
      if (set8_en) begin
         if (set8_idx == 3'd6) begin
            ex_we    = 1'b1;
            ex_waddr = hl;
            ex_wdata = val8;
         end else begin
            nxt8[set8_idx] = val8;
         end
      end
      // Write back a 16-bit target.
      if (set16_en) begin
         if (set16_idx == 2'd3) begin
            nsp = val16;
         end else begin
            nxt8[{set16_idx, 1'b0}] = val16[15:8];
            nxt8[{set16_idx, 1'b1}] = val16[7:0];
         end
      end
   end

   // Memory port selection by phase.
   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = ex_wdata;
      case (cmd.phase)
         PH_CMD_WR: begin
            mem_addr  = rq_addr_ff;
            mem_we    = 1'b1;
            mem_wdata = rq_data_ff;
         end
         PH_FETCH_OP: mem_addr = pc_ff;
         PH_FETCH_LO: mem_addr = pc_ff + 16'd1;
         PH_FETCH_HI: mem_addr = pc_ff + 16'd2;
         PH_OPND:     mem_addr = opnd_addr;
         PH_EXEC: begin
            mem_addr = ex_waddr;
            mem_we   = ex_we;
         end
         PH_WR2: begin
            mem_addr  = imm16 + 16'd1;
            mem_we    = 1'b1;
            mem_wdata = sp_ff[15:8];
         end
         default: mem_addr = rq_addr_ff;
      endcase
   end

   // Single-port byte memory with registered read.
   always_ff @(posedge clock) begin
      if (mem_we)
         mem_ff[mem_addr[AW-1:0]] <= mem_wdata;
      mem_q_ff <= mem_ff[mem_addr[AW-1:0]];
   end

   // Request capture and instruction byte latches.
   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         rq_op_ff   <= req_opcode;
         rq_addr_ff <= req_address;
         rq_data_ff <= req_data;
      end
      if (cmd.phase == PH_FETCH_LO)
         op_ff <= mem_q_ff;
      if (cmd.phase == PH_FETCH_HI)
         lo_ff <= mem_q_ff;
      if (cmd.phase == PH_OPND)
         hi_ff <= mem_q_ff;
   end

   // Architectural state and result flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff   <= RST_A;
         f_ff   <= RST_F;
         b_ff   <= RST_B;
         c_ff   <= RST_C;
         d_ff   <= RST_D;
         e_ff   <= RST_E;
         h_ff   <= RST_H;
         l_ff   <= RST_L;
         sp_ff  <= RST_SP;
         pc_ff  <= RST_PC;
         rd_ff  <= 8'h00;
         unk_ff <= 1'b0;
      end else begin
         if (cmd.take_req) begin
            rd_ff  <= 8'h00;
            unk_ff <= 1'b0;
         end
         if (cmd.phase == PH_RD_DONE && rq_op_ff == CMD_READ)
            rd_ff <= mem_q_ff;
         if (cmd.phase == PH_EXEC) begin
            b_ff   <= nxt8[0];
            c_ff   <= nxt8[1];
            d_ff   <= nxt8[2];
            e_ff   <= nxt8[3];
            h_ff   <= nxt8[4];
            l_ff   <= nxt8[5];
            a_ff   <= nxt8[7];
            f_ff   <= nf;
            sp_ff  <= nsp;
            pc_ff  <= npc;
            unk_ff <= ex_unk;
         end
      end
   end

   assign rsp_read_data           = rd_ff;
   assign rsp_program_counter     = pc_ff;
   assign rsp_accumulator         = a_ff;
   assign rsp_flag_bits           = f_ff;
   assign rsp_pair_bc             = {b_ff, c_ff};
   assign rsp_pair_de             = {d_ff, e_ff};
   assign rsp_pair_hl             = hl;
   assign rsp_stack_pointer       = sp_ff;
   assign rsp_unknown_instruction = unk_ff;

endmodule

// File: design/sm83_cpu_step_partial.sv
// Channel | Handshake                    | Word fields
// req     | req_valid / req_stall        | opcode, address, data
// rsp     | rsp_valid / rsp_stall        | read_data, program_counter, accumulator,
//         |                              | flag_bits, pair_bc/de/hl, stack_pointer,
//         |                              | unknown_instruction
// One word is in flight at a time; the single-port byte memory sets the pace.
// A memory write passes a write state, a read an address state and a data state, and
// the no-op command goes straight to the response state.
// An executed instruction runs opcode fetch, two immediate reads and an operand read,
// which share the one port, then executes; storing SP (two writes) adds a second write.
// Synchronous reset loads the register file; memory is not cleared.
// The response word holds until taken; req_stall stays high meanwhile.
module sm83_cpu_step_partial #(
   parameter int MEM_DEPTH = sm83_pkg::MEM_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic [15:0] rsp_program_counter,
   output logic [7:0]  rsp_accumulator,
   output logic [3:0]  rsp_flag_bits,
   output logic [15:0] rsp_pair_bc,
   output logic [15:0] rsp_pair_de,
   output logic [15:0] rsp_pair_hl,
   output logic [15:0] rsp_stack_pointer,
   output logic        rsp_unknown_instruction
);
   import sm83_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequencer.
   sm83_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .stat       (stat)
   );

   // Registers, execution logic and memory.
   sm83_dp #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .stat                    (stat),
      .req_opcode              (req_opcode),
      .req_address             (req_address),
      .req_data                (req_data),
      .rsp_read_data           (rsp_read_data),
      .rsp_program_counter     (rsp_program_counter),
      .rsp_accumulator         (rsp_accumulator),
      .rsp_flag_bits           (rsp_flag_bits),
      .rsp_pair_bc             (rsp_pair_bc),
      .rsp_pair_de             (rsp_pair_de),
      .rsp_pair_hl             (rsp_pair_hl),
      .rsp_stack_pointer       (rsp_stack_pointer),
      .rsp_unknown_instruction (rsp_unknown_instruction)
   );

endmodule

// File: sim/sm83_cpu_step_partial_checker.sv
`timescale 1ns / 100ps

module sm83_cpu_step_partial_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_read_data,
   input  logic [15:0] rsp_program_counter,
   input  logic [7:0]  rsp_accumulator,
   input  logic [3:0]  rsp_flag_bits,
   input  logic [15:0] rsp_pair_bc,
   input  logic [15:0] rsp_pair_de,
   input  logic [15:0] rsp_pair_hl,
   input  logic [15:0] rsp_stack_pointer,
   input  logic        rsp_unknown_instruction,
   output int          fail_count,
   output int          pending,
   output logic [15:0] cur_pc,
   output logic [15:0] cur_bc,
   output logic [15:0] cur_de,
   output logic [15:0] cur_hl
);
   import sm83_pkg::*;

   // Flag bit positions.
   localparam int FZ = 3;
   localparam int FN = 2;
   localparam int FH = 1;
   localparam int FC = 0;

   typedef struct {
      logic [7:0]  rdata;
      logic [15:0] pc;
      logic [7:0]  acc;
      logic [3:0]  flags;
      logic [15:0] bc;
      logic [15:0] de;
      logic [15:0] hl;
      logic [15:0] sp;
      logic        unk;
   } cpu_word_type;

   cpu_word_type cpu_words[$];

   // Shadow of the core: memory, which bytes hold a written value, and registers.
   logic [7:0]  mem [0:65535];
   bit          known [0:65535];
   logic [7:0]  ra, rb, rc, rd, re, rh, rl;
   logic [3:0]  rf;
   logic [15:0] rsp_reg, rpc;

   assign pending = cpu_words.size();
   assign cur_pc  = rpc;
   assign cur_bc  = {rb, rc};
   assign cur_de  = {rd, re};
   assign cur_hl  = {rh, rl};

   initial begin
      fail_count = 0;
      for (int i = 0; i < 65536; i++) begin
         mem[i]   = 8'h00;
         known[i] = 1'b0;
      end
   end

   task automatic mem_store(input logic [15:0] a, input logic [7:0] v);
      mem[a]   = v;
      known[a] = 1'b1;
   endtask

   function automatic logic [7:0] get_r8(input logic [2:0] idx);
      case (idx)
         3'd0: return rb;
         3'd1: return rc;
         3'd2: return rd;
         3'd3: return re;
         3'd4: return rh;
         3'd5: return rl;
         3'd6: return mem[{rh, rl}];
         default: return ra;
      endcase
   endfunction

   task automatic set_r8(input logic [2:0] idx, input logic [7:0] v);
      case (idx)
         3'd0: rb = v;
         3'd1: rc = v;
         3'd2: rd = v;
         3'd3: re = v;
         3'd4: rh = v;
         3'd5: rl = v;
         3'd6: mem_store({rh, rl}, v);
         default: ra = v;
      endcase
   endtask

   function automatic logic [15:0] get_r16(input logic [1:0] idx);
      case (idx)
         2'd0: return {rb, rc};
         2'd1: return {rd, re};
         2'd2: return {rh, rl};
         default: return rsp_reg;
      endcase
   endfunction

   task automatic set_r16(input logic [1:0] idx, input logic [15:0] v);
      case (idx)
         2'd0: {rb, rc} = v;
         2'd1: {rd, re} = v;
         2'd2: {rh, rl} = v;
         default: rsp_reg = v;
      endcase
   endtask

   // Executes the instruction at PC on the shadow state.
   task automatic run_instr(output logic unk);
      logic [7:0]  op, v, r, a, off;
      logic [15:0] imm, len, ad, y, p1, p2;
      logic [16:0] sum;
      logic [12:0] hsum;
      logic [2:0]  row;
      logic [1:0]  pr;
      logic        c, h, cout, take, jumped;
      p1     = rpc + 16'd1;
      p2     = rpc + 16'd2;
      op     = mem[rpc];
      row    = op[5:3];
      pr     = op[5:4];
      imm    = {mem[p2], mem[p1]};
      len    = 16'd1;
      unk    = 1'b0;
      jumped = 1'b0;
      take   = 1'b0;
      if (op >= 8'h80) begin
         unk = 1'b1;
      end else if (op >= 8'h40) begin
         // Register-to-register loads; HALT only advances.
         if (op != 8'h76) set_r8(row, get_r8(op[2:0]));
      end else if (op[2:0] == 3'd4) begin
         v = get_r8(row);
         r = v + 8'd1;
         set_r8(row, r);
         rf[FZ] = (r == 8'h00); rf[FN] = 1'b0; rf[FH] = (v[3:0] == 4'hF);
      end else if (op[2:0] == 3'd5) begin
         v = get_r8(row);
         r = v - 8'd1;
         set_r8(row, r);
         rf[FZ] = (r == 8'h00); rf[FN] = 1'b1; rf[FH] = (v[3:0] == 4'h0);
      end else if (op[2:0] == 3'd6) begin
         set_r8(row, mem[p1]);
         len = 16'd2;
      end else if (op[3:0] == 4'h1) begin
         set_r16(pr, imm);
         len = 16'd3;
      end else if (op[3:0] == 4'h3) begin
         set_r16(pr, get_r16(pr) + 16'd1);
      end else if (op[3:0] == 4'hB) begin
         set_r16(pr, get_r16(pr) - 16'd1);
      end else if (op[3:0] == 4'h9) begin
         // ADD HL: half carry from bit 11, carry from bit 15, Z kept.
         y      = get_r16(pr);
         sum    = {1'b0, rh, rl} + {1'b0, y};
         hsum   = {1'b0, rh[3:0], rl} + {1'b0, y[11:0]};
         rf[FN] = 1'b0;
         rf[FH] = hsum[12];
         rf[FC] = sum[16];
         {rh, rl} = sum[15:0];
      end else if (op[3:0] == 4'h2 || op[3:0] == 4'hA) begin
         ad = (pr < 2'd2) ? get_r16(pr) : {rh, rl};
         if (op[3:0] == 4'h2) mem_store(ad, ra);
         else ra = mem[ad];
         if (pr == 2'd2) {rh, rl} = ad + 16'd1;
         if (pr == 2'd3) {rh, rl} = ad - 16'd1;
      end else begin
         case (op)
            8'h00, 8'h10: ;
            OP_LD_A16_SP: begin
               mem_store(imm, rsp_reg[7:0]);
               mem_store(imm + 16'd1, rsp_reg[15:8]);
               len = 16'd3;
            end
            8'h07: begin cout = ra[7]; ra = {ra[6:0], ra[7]}; rf = {3'b000, cout}; end
            8'h0F: begin cout = ra[0]; ra = {ra[0], ra[7:1]}; rf = {3'b000, cout}; end
            8'h17: begin cout = ra[7]; ra = {ra[6:0], rf[FC]}; rf = {3'b000, cout}; end
            8'h1F: begin cout = ra[0]; ra = {rf[FC], ra[7:1]}; rf = {3'b000, cout}; end
            8'h18, 8'h20, 8'h28, 8'h30, 8'h38: begin
               case (op)
                  8'h18: take = 1'b1;
                  8'h20: take = !rf[FZ];
                  8'h28: take = rf[FZ];
                  8'h30: take = !rf[FC];
                  default: take = rf[FC];
               endcase
               // Relative jump from the address after the two-byte instruction.
               off = mem[p1];
               rpc = p2;
               if (take) rpc = rpc + {{8{off[7]}}, off};
               jumped = 1'b1;
            end
            8'h27: begin
               a = ra; c = rf[FC]; h = rf[FH];
               if (!rf[FN]) begin
                  if (c || a > 8'h99) begin a = a + 8'h60; c = 1'b1; end
                  if (h || a[3:0] > 4'h9) a = a + 8'h06;
               end else begin
                  if (c) a = a - 8'h60;
                  if (h) a = a - 8'h06;
               end
               ra = a;
               rf[FZ] = (a == 8'h00); rf[FH] = 1'b0; rf[FC] = c;
            end
            8'h2F: begin ra = ~ra; rf[FN] = 1'b1; rf[FH] = 1'b1; end
            8'h37: begin rf[FN] = 1'b0; rf[FH] = 1'b0; rf[FC] = 1'b1; end
            default: begin rf[FN] = 1'b0; rf[FH] = 1'b0; rf[FC] = !rf[FC]; end
         endcase
      end
      if (!jumped) rpc = rpc + len;
   endtask

   task automatic report_bad(input string field, input logic [15:0] got, input logic [15:0] want);
      $display("mismatch at %0t: %s got %h, want %h", $realtime, field, got, want);
      fail_count++;
   endtask

   // Check the result word first, then predict for a newly accepted request word.
   always @(posedge clock) begin
      cpu_word_type w, e;
      logic      unk;
      logic [7:0] rdv;
      if (reset) begin
         ra = RST_A; rf = RST_F; rb = RST_B; rc = RST_C; rd = RST_D;
         re = RST_E; rh = RST_H; rl = RST_L; rsp_reg = RST_SP; rpc = RST_PC;
         cpu_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (cpu_words.size() == 0) begin
               report_bad("unexpected word", 16'h0, 16'h0);
            end else begin
               e = cpu_words.pop_front();
               if (rsp_read_data !== e.rdata)
                  report_bad("read_data", 16'(rsp_read_data), 16'(e.rdata));
               if (rsp_program_counter !== e.pc)
                  report_bad("program_counter", rsp_program_counter, e.pc);
               if (rsp_accumulator !== e.acc)
                  report_bad("accumulator", 16'(rsp_accumulator), 16'(e.acc));
               if (rsp_flag_bits !== e.flags)
                  report_bad("flag_bits", 16'(rsp_flag_bits), 16'(e.flags));
               if (rsp_pair_bc !== e.bc) report_bad("pair_bc", rsp_pair_bc, e.bc);
               if (rsp_pair_de !== e.de) report_bad("pair_de", rsp_pair_de, e.de);
               if (rsp_pair_hl !== e.hl) report_bad("pair_hl", rsp_pair_hl, e.hl);
               if (rsp_stack_pointer !== e.sp)
                  report_bad("stack_pointer", rsp_stack_pointer, e.sp);
               if (rsp_unknown_instruction !== e.unk)
                  report_bad("unknown_instruction", 16'(rsp_unknown_instruction),
                             16'(e.unk));
            end
         end
         if (req_valid && !req_stall) begin
            rdv = 8'h00;
            unk = 1'b0;
            case (req_opcode)
               CMD_WRITE: mem_store(req_address, req_data);
               CMD_EXEC:  run_instr(unk);
               CMD_READ:  rdv = mem[req_address];
               default: ;
            endcase
            w.rdata = rdv;   w.pc = rpc;        w.acc = ra;       w.flags = rf;
            w.bc = {rb, rc}; w.de = {rd, re};   w.hl = {rh, rl};  w.sp = rsp_reg;
            w.unk = unk;
            cpu_words.push_back(w);
         end
      end
   end

endmodule

// File: sim/sm83_cpu_step_partial_tb.sv
`timescale 1ns / 100ps

module sm83_cpu_step_partial_tb;
   import sm83_pkg::*;

   localparam int WATCH_LIMIT = 3000;

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [1:0]  req_opcode;
   logic [15:0] req_address;
   logic [7:0]  req_data;
   logic        rsp_valid, rsp_stall;
   logic [7:0]  rsp_read_data;
   logic [15:0] rsp_program_counter;
   logic [7:0]  rsp_accumulator;
   logic [3:0]  rsp_flag_bits;
   logic [15:0] rsp_pair_bc, rsp_pair_de, rsp_pair_hl, rsp_stack_pointer;
   logic        rsp_unknown_instruction;

   int          fail_count, pending;
   logic [15:0] cur_pc, cur_bc, cur_de, cur_hl;

   int          send_idle_pct, recv_idle_pct;
   int          words_sent;
   bit          hold_request;
   logic [15:0] last_written;
   int          quiet_cycles;

   sm83_cpu_step_partial u_dut (.*);

   sm83_cpu_step_partial_checker u_chk (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // Receiver: random stalls, plus one long hold-off once the 120th word has been sent.
   always @(negedge clock) begin
      static int hold_left = 0;
      static bit hold_done = 0;
      if (hold_request && !hold_done) begin
         hold_done = 1;
         hold_left = 120;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog on cycles with no accepted word on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCH_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Offers one request word and returns after it is accepted, just past the falling edge.
   task automatic send_word(input logic [1:0] op, input logic [15:0] addr,
                            input logic [7:0] dat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         req_opcode = 2'($urandom);
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_opcode  = op;
      req_address = addr;
      req_data    = dat;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (op == CMD_WRITE) last_written = addr;
      words_sent++;
      if (words_sent == 170) begin send_idle_pct = 46; recv_idle_pct = 18; end
      if (words_sent == 340) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      if (words_sent == 120) hold_request = 1'b1;
   endtask

   // Reads only from bytes that hold a written value.
   task automatic read_known(input logic [15:0] addr);
      if (u_chk.known[addr]) send_word(CMD_READ, addr, 8'($urandom));
      else send_word(CMD_READ, last_written, 8'($urandom));
   endtask

   // Places an instruction and the bytes it reads, then executes it.
   task automatic run_op(input logic [7:0] op, input bit fix_imm, input logic [15:0] imm);
      logic [15:0] opnd, pc;
      bit          needs;
      needs = 1'b0;
      opnd  = cur_hl;
      if (op >= 8'h40 && op < 8'h80 && op != 8'h76 && op[2:0] == 3'd6) needs = 1'b1;
      if (op == 8'h34 || op == 8'h35 || op == 8'h2A || op == 8'h3A) needs = 1'b1;
      if (op == 8'h0A) begin needs = 1'b1; opnd = cur_bc; end
      if (op == 8'h1A) begin needs = 1'b1; opnd = cur_de; end
      if (needs && !u_chk.known[opnd]) send_word(CMD_WRITE, opnd, 8'($urandom));
      pc = cur_pc;
      send_word(CMD_WRITE, pc, op);
      if (fix_imm || !u_chk.known[pc + 16'd1] || $urandom_range(1))
         send_word(CMD_WRITE, pc + 16'd1, fix_imm ? imm[7:0] : 8'($urandom));
      if (fix_imm || !u_chk.known[pc + 16'd2] || $urandom_range(1))
         send_word(CMD_WRITE, pc + 16'd2, fix_imm ? imm[15:8] : 8'($urandom));
      send_word(CMD_EXEC, 16'($urandom), 8'($urandom));
   endtask

   initial begin
      int sel;
      logic [7:0] op;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_opcode    = CMD_WRITE;
      req_address   = 16'h0000;
      req_data      = 8'h00;
      rsp_stall     = 1'b0;
      send_idle_pct = 18;
      recv_idle_pct = 46;
      words_sent    = 0;
      hold_request  = 1'b0;
      last_written  = 16'h0000;
      quiet_cycles  = 0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed: memory extremes, the no-op command and a few special instructions.
      send_word(CMD_WRITE, 16'h0000, 8'h00);
      send_word(CMD_WRITE, 16'hFFFF, 8'hFF);
      send_word(CMD_READ, 16'hFFFF, 8'h00);
      send_word(CMD_READ, 16'h0000, 8'hFF);
      send_word(CMD_NOP, 16'hFFFF, 8'hFF);
      run_op(8'h76, 1'b0, 16'h0);
      run_op(8'h10, 1'b0, 16'h0);
      run_op(8'hFF, 1'b0, 16'h0);
      run_op(OP_LD_A16_SP, 1'b1, 16'hFFFF);
      read_known(16'h0000);
      run_op(8'h27, 1'b0, 16'h0);
      run_op(8'h3F, 1'b0, 16'h0);
      run_op(8'h18, 1'b1, 16'h0080);

      // Random mix, mostly instructions with their bytes placed just ahead.
      while (words_sent < 500) begin
         sel = $urandom_range(9);
         if (sel <= 5) begin
            op = ($urandom_range(9) == 0) ? 8'(8'h80 | $urandom) : 8'($urandom & 8'h7F);
            run_op(op, 1'b0, 16'h0);
         end else if (sel <= 7) begin
            send_word(CMD_WRITE, 16'($urandom), 8'($urandom));
         end else if (sel == 8) begin
            read_known(16'($urandom));
         end else begin
            send_word(CMD_NOP, 16'($urandom), 8'($urandom));
         end
      end
      req_valid = 1'b0;

      wait (pending == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: sim.f
+incdir+design
design/sm83_pkg.sv
design/sm83_ctrl.sv
design/sm83_dp.sv
design/sm83_cpu_step_partial.sv
sim/sm83_cpu_step_partial_checker.sv
sim/sm83_cpu_step_partial_tb.sv
